// File: src/lcb_pkg.sv
// Shared types, field layouts and codes of the least-connections balancer with breakers.
`default_nettype none
package lcb_pkg;

    localparam int FUNC_W     = 2;
    localparam int NOW_W      = 48;
    localparam int SLOT_W     = 3;
    localparam int ID_W       = 3;
    localparam int CNT_W      = 4;
    localparam int OUTC_W     = 3;
    localparam int LOAD_W     = 4;
    localparam int FAIL_W     = 8;
    localparam int LEN_W      = 32;
    localparam int CUR_W      = 4;
    localparam int CAP_W      = 4;
    localparam int CHK_W      = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 40;

    localparam logic [FUNC_W-1:0] FUNC_ROSTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd2;

    localparam logic [OUTC_W-1:0] OUT_DONE    = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_ERROR   = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_REFUSED = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_TIMEOUT = 3'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_INFLIGHT_CAP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_STREAK    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BENCH_FIRST_MS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BENCH_MAX_MS   = 2'd3;

    localparam logic [CAP_W-1:0]  CAP_RST    = 4'd4;
    localparam logic [FAIL_W-1:0] STREAK_RST = 8'd3;
    localparam logic [LEN_W-1:0]  FIRST_RST  = 32'd15000;
    localparam logic [LEN_W-1:0]  MAX_RST    = 32'd240000;

    // Input word layout; now_ms sits in the lowest bits.
    typedef struct packed {
        logic [1:0]        spare;
        logic              heard_back;
        logic [OUTC_W-1:0] outcome;
        logic [CNT_W-1:0]  roster_count;
        logic [ID_W-1:0]   node_id;
        logic [SLOT_W-1:0] roster_slot;
        logic [NOW_W-1:0]  now_ms;
    } in_t;

    // Result word layout; picked sits in bit 0.
    typedef struct packed {
        logic [LEN_W-1:0]  bench_len_ms;
        logic              bench_started;
        logic [ID_W-1:0]   pick_id;
        logic [SLOT_W-1:0] pick_slot;
        logic              picked;
    } result_t;

    // One entry of the per-node memory.
    typedef struct packed {
        logic [LOAD_W-1:0] load;
        logic [FAIL_W-1:0] fail_run;
        logic [NOW_W-1:0]  bench_end;
        logic [LEN_W-1:0]  len;
    } node_t;

    typedef struct packed {
        logic [FAIL_W-1:0] streak;
        logic [LEN_W-1:0]  first;
        logic [LEN_W-1:0]  max_len;
    } brk_cfg_t;

    typedef struct packed {
        logic             bench;
        logic [LEN_W-1:0] len;
    } brk_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROSTER,
        ST_PCHK,
        ST_MOD,
        ST_SCAN,
        ST_COMMIT,
        ST_CRD,
        ST_CSTART,
        ST_CWAIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: src/lcb_judge.sv
// Two-stage breaker update for one node entry on a connection close.
`default_nettype none
module lcb_judge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  lcb_pkg::node_t               ent_in,
    input  logic [lcb_pkg::OUTC_W-1:0]   outcome,
    input  logic                         heard,
    input  logic [lcb_pkg::NOW_W-1:0]    now_ms,
    input  lcb_pkg::brk_cfg_t            cfg,
    output logic                         done,
    output lcb_pkg::node_t               ent_out,
    output lcb_pkg::brk_res_t            res
);
    import lcb_pkg::*;

    logic              forgive;
    logic              failed;
    logic              bench_a;
    logic [FAIL_W-1:0] fail_inc;
    logic [FAIL_W-1:0] need;
    logic [LEN_W:0]    dbl;
    logic [LEN_W-1:0]  len_a;
    node_t             ent_a;

    logic              a_vld_reg;
    node_t             a_ent_reg;
    logic              a_bench_reg;
    logic [LEN_W-1:0]  a_len_reg;

    logic [NOW_W:0]    sum_b;
    logic [NOW_W-1:0]  until_b;
    node_t             ent_b;
    brk_res_t          res_b;

    logic              done_reg;
    node_t             ent_out_reg;
    brk_res_t          res_reg;

    // Stage A: load release, streak count and bench length.
    always_comb begin
        forgive  = (outcome == OUT_DONE) || heard;
        failed   = (outcome == OUT_ERROR) || (outcome == OUT_REFUSED) ||
                   (outcome == OUT_TIMEOUT);
        fail_inc = (ent_in.fail_run == '1) ? ent_in.fail_run : ent_in.fail_run + 1'b1;
        need     = (ent_in.len != '0) ? FAIL_W'(1) : cfg.streak;
        dbl      = {ent_in.len, 1'b0};
        if (ent_in.len == '0) begin
            len_a = cfg.first;
        end else if (dbl > {1'b0, cfg.max_len}) begin
            len_a = cfg.max_len;
        end else begin
            len_a = dbl[LEN_W-1:0];
        end
        ent_a      = ent_in;
        ent_a.load = (ent_in.load != '0) ? ent_in.load - 1'b1 : '0;
        bench_a    = 1'b0;
        if (forgive) begin
            ent_a.fail_run  = '0;
            ent_a.bench_end = '0;
            ent_a.len       = '0;
        end else if (failed) begin
            ent_a.fail_run = fail_inc;
            bench_a        = (fail_inc >= need);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        a_ent_reg   <= ent_a;
        a_bench_reg <= bench_a;
        a_len_reg   <= len_a;
    end

    // Stage B: bench end time, saturated at the top of the time range.
    always_comb begin
        sum_b   = (NOW_W+1)'(now_ms) + (NOW_W+1)'(a_len_reg);
        until_b = sum_b[NOW_W] ? '1 : sum_b[NOW_W-1:0];
        ent_b   = a_ent_reg;
        if (a_bench_reg) begin
            ent_b.bench_end = until_b;
            ent_b.len       = a_len_reg;
            ent_b.fail_run  = '0;
        end
        res_b.bench = a_bench_reg;
        res_b.len   = a_bench_reg ? a_len_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ent_out_reg <= ent_b;
        res_reg     <= res_b;
    end

    assign done    = done_reg;
    assign ent_out = ent_out_reg;
    assign res     = res_reg;

endmodule
`default_nettype wire

// File: src/least_conn_balancer_breaker.sv
// Least-connections backend picker with a circuit breaker per node id.
//
//  Channel   Ports                            Moves
//  input     s_tvalid s_tready s_tdata s_tuser  one command word
//  result    m_tvalid m_tready m_tdata          one result word per command
//  config    cfg_we cfg_addr cfg_wdata          register write, no read-back
//
// One command is worked at a time. A roster write writes the roster entry, and a
// close goes through the node memory read and the two-stage breaker unit. A pick
// takes M cursor reduction steps (at most 8), then P scan passes (1 or 2) over N
// roster entries, one entry per cycle through the roster and node memory reads.
// aresetn is synchronous; the valid bits of both memories clear at once, so no
// clearing pass is needed.
// A new command is taken while the previous result still waits on m_tready.
`default_nettype none
module least_conn_balancer_breaker #(
    parameter int ROSTER_DEPTH = 8,
    parameter int ID_COUNT     = 8,
    parameter int PAIR_SLOTS   = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[47:0], roster_slot[50:48], node_id[53:51], roster_count[57:54],
    // outcome[60:58], heard_back[61], zero[63:62]
    input  logic [lcb_pkg::S_DATA_W-1:0]      s_tdata,
    // func
    input  logic [lcb_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // picked[0], pick_slot[3:1], pick_id[6:4], bench_started[7], bench_len_ms[39:8]
    output logic [lcb_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_we,
    input  logic [lcb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lcb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import lcb_pkg::*;

    localparam int RAW = (ROSTER_DEPTH > 1) ? $clog2(ROSTER_DEPTH) : 1;
    localparam int IDW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int RSW = $clog2(ROSTER_DEPTH + 1);
    localparam int IXW = (RSW > CUR_W) ? RSW : CUR_W;
    localparam int TW  = $clog2(PAIR_SLOTS + 1);

    // Configuration registers.
    logic [CAP_W-1:0]  cap_reg;
    logic [FAIL_W-1:0] streak_reg;
    logic [LEN_W-1:0]  first_reg;
    logic [LEN_W-1:0]  max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RST;
            streak_reg <= STREAK_RST;
            first_reg  <= FIRST_RST;
            max_reg    <= MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_INFLIGHT_CAP:   cap_reg    <= cfg_wdata[CAP_W-1:0];
                CFG_FAIL_STREAK:    streak_reg <= cfg_wdata[FAIL_W-1:0];
                CFG_BENCH_FIRST_MS: first_reg  <= cfg_wdata;
                CFG_BENCH_MAX_MS:   max_reg    <= cfg_wdata;
            endcase
        end
    end

    // Control and datapath registers.
    state_t            state_reg, state_next;
    in_t               in_reg, in_next;
    logic [RSW-1:0]    size_reg, size_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [IXW-1:0]    start_reg, start_next;
    logic [IXW-1:0]    iss_reg, iss_next;
    logic [RSW-1:0]    k_reg, k_next;
    logic              honor_reg, honor_next;
    logic              p1_vld_reg, p1_vld_next;
    logic [RAW-1:0]    p1_idx_reg, p1_idx_next;
    logic              p2_vld_reg, p2_vld_next;
    logic [RAW-1:0]    p2_idx_reg, p2_idx_next;
    logic [ID_W-1:0]   p2_id_reg, p2_id_next;
    logic              best_vld_reg, best_vld_next;
    logic [RAW-1:0]    best_idx_reg, best_idx_next;
    logic [LOAD_W-1:0] best_load_reg, best_load_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    node_t             best_ent_reg, best_ent_next;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    result_t           out_reg, out_next;

    // Memory ports.
    logic              roster_we;
    logic [RAW-1:0]    roster_waddr;
    logic              roster_re;
    logic [RAW-1:0]    roster_raddr;
    logic              node_we;
    logic [IDW-1:0]    node_waddr;
    node_t             node_wdata;
    logic              node_re;
    logic [IDW-1:0]    node_raddr;

    logic [ID_W-1:0]   roster_mem [ROSTER_DEPTH];
    logic [ROSTER_DEPTH-1:0] roster_vld_reg;
    logic [ID_W-1:0]   roster_rd_reg;
    logic              roster_rv_reg;
    node_t             node_mem [ID_COUNT];
    logic [ID_COUNT-1:0] node_vld_reg;
    node_t             node_rd_reg;
    logic              node_rv_reg;

    logic [ID_W-1:0]   roster_id_q;
    node_t             node_q;

    // Breaker unit.
    logic              j_start;
    logic              j_done;
    node_t             j_ent;
    brk_res_t          j_res;
    brk_cfg_t          j_cfg;

    // Scan evaluation.
    logic              issue;
    logic              id_ok1;
    logic              id_ok2;
    logic              benched;
    logic              cand;
    logic              zero_hit;
    logic              scan_end;
    logic              found;
    logic [IXW-1:0]    iss_wrap;
    in_t               s_word;

    assign s_word = in_t'(s_tdata);

    // Entries never written read as zero.
    assign roster_id_q = roster_rv_reg ? roster_rd_reg : '0;
    assign node_q      = node_rv_reg ? node_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (roster_we) begin
            roster_mem[roster_waddr] <= in_reg.node_id;
        end
        if (roster_re) begin
            roster_rd_reg <= roster_mem[roster_raddr];
            roster_rv_reg <= roster_vld_reg[roster_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rd_reg <= node_mem[node_raddr];
            node_rv_reg <= node_vld_reg[node_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roster_vld_reg <= '0;
            node_vld_reg   <= '0;
        end else begin
            if (roster_we) begin
                roster_vld_reg[roster_waddr] <= 1'b1;
            end
            if (node_we) begin
                node_vld_reg[node_waddr] <= 1'b1;
            end
        end
    end

    assign j_cfg.streak  = streak_reg;
    assign j_cfg.first   = first_reg;
    assign j_cfg.max_len = max_reg;

    lcb_judge u_judge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (j_start),
        .ent_in  (node_q),
        .outcome (in_reg.outcome),
        .heard   (in_reg.heard_back),
        .now_ms  (in_reg.now_ms),
        .cfg     (j_cfg),
        .done    (j_done),
        .ent_out (j_ent),
        .res     (j_res)
    );

    // Scan pipeline: issue a roster read, then a node read, then compare.
    always_comb begin
        issue    = (state_reg == ST_SCAN) && (k_reg != size_reg);
        iss_wrap = (iss_reg + 1'b1 == IXW'(size_reg)) ? '0 : iss_reg + 1'b1;
        id_ok1   = CHK_W'(roster_id_q) < CHK_W'(ID_COUNT);
        id_ok2   = CHK_W'(p2_id_reg) < CHK_W'(ID_COUNT);
        benched  = (node_q.bench_end != '0) && (in_reg.now_ms < node_q.bench_end);
        cand     = p2_vld_reg && id_ok2 && !(honor_reg && benched) &&
                   (node_q.load < best_load_reg);
        zero_hit = cand && (node_q.load == '0);
        scan_end = zero_hit || ((k_reg == size_reg) && !p1_vld_reg && !p2_vld_reg);
        found    = best_vld_reg || cand;
    end

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        size_next      = size_reg;
        cursor_next    = cursor_reg;
        total_next     = total_reg;
        start_next     = start_reg;
        iss_next       = iss_reg;
        k_next         = k_reg;
        honor_next     = honor_reg;
        p1_vld_next    = 1'b0;
        p1_idx_next    = p1_idx_reg;
        p2_vld_next    = 1'b0;
        p2_idx_next    = p2_idx_reg;
        p2_id_next     = p2_id_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_load_next = best_load_reg;
        best_id_next   = best_id_reg;
        best_ent_next  = best_ent_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_next       = out_reg;
        s_tready       = 1'b0;
        roster_we      = 1'b0;
        roster_waddr   = RAW'(in_reg.roster_slot);
        roster_re      = 1'b0;
        roster_raddr   = RAW'(iss_reg);
        node_we        = 1'b0;
        node_waddr     = IDW'(in_reg.node_id);
        node_wdata     = j_ent;
        node_re        = 1'b0;
        node_raddr     = IDW'(in_reg.node_id);
        j_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_next   = s_word;
                    res_next  = '0;
                    unique case (s_tuser)
                        FUNC_ROSTER: state_next = ST_ROSTER;
                        FUNC_PICK:   state_next = ST_PCHK;
                        FUNC_CLOSE:  state_next = ST_CRD;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ROSTER: begin
                roster_we = CHK_W'(in_reg.roster_slot) < CHK_W'(ROSTER_DEPTH);
                if (CHK_W'(in_reg.roster_count) > CHK_W'(ROSTER_DEPTH)) begin
                    size_next = RSW'(ROSTER_DEPTH);
                end else begin
                    size_next = RSW'(in_reg.roster_count);
                end
                state_next = ST_DONE;
            end
            ST_PCHK: begin
                if ((total_reg >= TW'(PAIR_SLOTS)) || (size_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    start_next     = IXW'(cursor_reg);
                    honor_next     = 1'b1;
                    best_vld_next  = 1'b0;
                    best_load_next = cap_reg;
                    state_next     = ST_MOD;
                end
            end
            ST_MOD: begin
                // The cursor may lie past a roster that shrank; reduce it modulo the size.
                if (start_reg >= IXW'(size_reg)) begin
                    start_next = start_reg - IXW'(size_reg);
                end else begin
                    iss_next   = start_reg;
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    roster_re   = 1'b1;
                    iss_next    = iss_wrap;
                    k_next      = k_reg + 1'b1;
                    p1_vld_next = 1'b1;
                    p1_idx_next = RAW'(iss_reg);
                end
                if (p1_vld_reg) begin
                    node_re    = 1'b1;
                    node_raddr = id_ok1 ? IDW'(roster_id_q) : '0;
                end
                p2_vld_next = p1_vld_reg;
                p2_idx_next = p1_idx_reg;
                p2_id_next  = roster_id_q;
                if (cand) begin
                    best_vld_next  = 1'b1;
                    best_idx_next  = p2_idx_reg;
                    best_load_next = node_q.load;
                    best_id_next   = p2_id_reg;
                    best_ent_next  = node_q;
                end
                if (scan_end) begin
                    p1_vld_next = 1'b0;
                    p2_vld_next = 1'b0;
                    if (found) begin
                        state_next = ST_COMMIT;
                    end else if (honor_reg) begin
                        // Nothing outside the bench qualified: scan again ignoring it.
                        honor_next     = 1'b0;
                        iss_next       = start_reg;
                        k_next         = '0;
                        best_load_next = cap_reg;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_COMMIT: begin
                node_we            = 1'b1;
                node_waddr         = IDW'(best_id_reg);
                node_wdata         = best_ent_reg;
                node_wdata.load    = best_ent_reg.load + 1'b1;
                total_next         = total_reg + 1'b1;
                cursor_next        = CUR_W'({1'b0, best_idx_reg} + 1'b1);
                res_next.picked    = 1'b1;
                res_next.pick_slot = SLOT_W'(best_idx_reg);
                res_next.pick_id   = best_id_reg;
                state_next         = ST_DONE;
            end
            ST_CRD: begin
                if (CHK_W'(in_reg.node_id) < CHK_W'(ID_COUNT)) begin
                    node_re    = 1'b1;
                    state_next = ST_CSTART;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CSTART: begin
                j_start    = 1'b1;
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (j_done) begin
                    node_we = 1'b1;
                    if (node_q.load != '0) begin
                        total_next = total_reg - 1'b1;
                    end
                    res_next.bench_started = j_res.bench;
                    res_next.bench_len_ms  = j_res.len;
                    state_next             = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_next      = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= '0;
            cursor_reg   <= '0;
            total_reg    <= '0;
            honor_reg    <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            cursor_reg   <= cursor_next;
            total_reg    <= total_next;
            honor_reg    <= honor_next;
            p1_vld_reg   <= p1_vld_next;
            p2_vld_reg   <= p2_vld_next;
            best_vld_reg <= best_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        start_reg     <= start_next;
        iss_reg       <= iss_next;
        p1_idx_reg    <= p1_idx_next;
        p2_idx_reg    <= p2_idx_next;
        p2_id_reg     <= p2_id_next;
        best_idx_reg  <= best_idx_next;
        best_load_reg <= best_load_next;
        best_id_reg   <= best_id_next;
        best_ent_reg  <= best_ent_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    // The running load total never passes the pair limit.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TW'(PAIR_SLOTS))
        else $error("load total above pair limit");

    // A pick commits only with a chosen entry.
    a_commit_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |-> best_vld_reg)
        else $error("commit without a chosen backend");

    // The scan pointer stays inside the roster.
    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (iss_reg < IXW'(size_reg)))
        else $error("scan index outside roster");

    // The best load never rises above the cap during a scan.
    a_best_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (best_load_reg <= cap_reg))
        else $error("best load above cap");

    // Breaker results arrive only while a close waits for them.
    a_judge_done: assert property (@(posedge aclk) disable iff (!aresetn)
        j_done |-> (state_reg == ST_CWAIT) && ($past(state_reg, 2) == ST_CSTART))
        else $error("breaker result outside close");
`endif

endmodule
`default_nettype wire
